// ===== hw/rtl/dslst_pkg.sv =====
package dslst_pkg;

   localparam int ANGLE_W = 18;

   localparam logic [ANGLE_W-1:0] ANGLE_MAX      = 18'd180000;
   localparam logic [ANGLE_W-1:0] CENTER_ANGLE   = 18'd90000;
   localparam logic [ANGLE_W-1:0] GIVE_UP_ANGLE  = 18'd160000;
   localparam logic [ANGLE_W-1:0] RESTART_MARGIN = 18'd2000;
   localparam logic [9:0]         NO_BLOB        = 10'd1023;
   localparam logic [4:0]         CNT_MAX        = 5'd31;

   // degrees = (mdeg * DEG_RECIP) >> DEG_SHIFT, exact for every mdeg up to ANGLE_MAX
   localparam int          DEG_SHIFT = 28;
   localparam logic [18:0] DEG_RECIP = 19'd268436;

   localparam logic [3:0] CMD_IDLE        = 4'd0;
   localparam logic [3:0] CMD_SEARCH      = 4'd1;
   localparam logic [3:0] CMD_FOLLOW      = 4'd2;
   localparam logic [3:0] CMD_EXTINGUISH  = 4'd3;
   localparam logic [3:0] CMD_REPORT      = 4'd4;
   localparam logic [3:0] CMD_CENTER      = 4'd5;
   localparam logic [3:0] CMD_IDLE_ALT_LO = 4'd6;
   localparam logic [3:0] CMD_IDLE_ALT_HI = 4'd9;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_SEARCH = 2'd1,
      MODE_FOLLOW = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      EV_NONE       = 3'd0,
      EV_FOUND      = 3'd1,
      EV_NOT_FOUND  = 3'd2,
      EV_EXTINGUISH = 3'd3,
      EV_REPORT     = 3'd4
   } event_type;

   typedef enum logic [3:0] {
      REG_DEADBAND = 4'd0,
      REG_GAIN     = 4'd1,
      REG_CENTER   = 4'd2,
      REG_STEP     = 4'd3,
      REG_CONFIRM  = 4'd4,
      REG_FLOOR    = 4'd5,
      REG_LIMIT    = 4'd6,
      REG_RESTART  = 4'd7
   } reg_index_type;

   localparam logic [8:0]         RST_DEADBAND = 9'd30;
   localparam logic [7:0]         RST_GAIN     = 8'd5;
   localparam logic [9:0]         RST_CENTER   = 10'd512;
   localparam logic [13:0]        RST_STEP     = 14'd500;
   localparam logic [4:0]         RST_CONFIRM  = 5'd10;
   localparam logic [ANGLE_W-1:0] RST_FLOOR    = 18'd10000;
   localparam logic [ANGLE_W-1:0] RST_LIMIT    = 18'd170000;
   localparam logic [ANGLE_W-1:0] RST_RESTART  = 18'd20000;

   typedef struct packed {
      logic [8:0]         deadband;
      logic [7:0]         gain;
      logic [9:0]         center;
      logic [13:0]        sweep_step;
      logic [4:0]         confirm;
      logic [ANGLE_W-1:0] floor_mdeg;
      logic [ANGLE_W-1:0] limit_mdeg;
      logic [ANGLE_W-1:0] restart_mdeg;
   } cfg_type;

   typedef struct packed {
      logic [ANGLE_W-1:0] left_angle;
      logic [ANGLE_W-1:0] right_angle;
      mode_type           mode;
      logic [4:0]         counter;
   } track_state_type;

   typedef struct packed {
      logic       kind;
      logic [3:0] command;
      logic [9:0] left_x;
      logic [9:0] right_x;
   } item_type;

   function automatic logic [7:0] mdeg_to_deg(logic [ANGLE_W-1:0] mdeg);
      logic [36:0] prod;
      prod = 37'(mdeg) * 37'(DEG_RECIP);
      return prod[DEG_SHIFT+7:DEG_SHIFT];
   endfunction

endpackage

// ===== hw/rtl/dslst_channels.sv =====
interface dslst_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [3:0] command;
   logic [9:0] left_x;
   logic [9:0] right_x;

   modport source (output valid, kind, command, left_x, right_x, input ready);
   modport sink   (input valid, kind, command, left_x, right_x, output ready);
endinterface

interface dslst_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] left_servo_deg;
   logic [7:0] right_servo_deg;
   logic [1:0] active_mode;
   logic [2:0] event_res;

   modport source (output valid, left_servo_deg, right_servo_deg, active_mode, event_res,
                   input ready);
   modport sink   (input valid, left_servo_deg, right_servo_deg, active_mode, event_res,
                   output ready);
endinterface

interface dslst_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [17:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/dual_servo_light_search_track_unit.sv =====
// Channel  Dir  Handshake     Payload
// req_bus  in   valid/ready   kind, command, left_x, right_x
// rsp_bus  out  valid/ready   left_servo_deg, right_servo_deg, active_mode, event_res
// csr_bus  in   valid/ready   index (register number), data
//
// Each req_bus transfer gives one rsp_bus transfer via input, middle and output stages.
// One item per cycle unless stalled: the angle/mode/counter update is combinational
// logic after the input register; the degree conversion multiplier is in the next stage.
// Synchronous reset restores register defaults, centers both angles and selects idle.
// A stalled response holds every stage behind it; req_bus.ready drops only when all
// stages are full. csr_bus.ready is always high.
module dual_servo_light_search_track_unit (
   input logic        clock,
   input logic        reset,
   dslst_req_if.sink  req_bus,
   dslst_rsp_if.source rsp_bus,
   dslst_csr_if.sink  csr_bus
);

   dslst_pkg::cfg_type         cfg_ff;
   dslst_pkg::track_state_type state_ff;
   dslst_pkg::track_state_type state_in;
   dslst_pkg::event_type       step_ev;

   logic                       a_valid_ff;
   dslst_pkg::item_type        a_item_ff;
   logic                       b_valid_ff;
   dslst_pkg::track_state_type b_state_ff;
   dslst_pkg::event_type       b_ev_ff;
   logic                       rsp_valid_ff;
   logic [7:0]                 rsp_left_ff;
   logic [7:0]                 rsp_right_ff;
   logic [1:0]                 rsp_mode_ff;
   logic [2:0]                 rsp_ev_ff;

   logic out_free;
   logic b_move;
   logic b_free;
   logic a_move;
   logic a_free;
   logic req_take;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign b_move   = b_valid_ff && out_free;
   assign b_free   = !b_valid_ff || out_free;
   assign a_move   = a_valid_ff && b_free;
   assign a_free   = !a_valid_ff || b_free;
   assign req_take = req_bus.valid && a_free;

   assign req_bus.ready = a_free;
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.deadband     <= dslst_pkg::RST_DEADBAND;
         cfg_ff.gain         <= dslst_pkg::RST_GAIN;
         cfg_ff.center       <= dslst_pkg::RST_CENTER;
         cfg_ff.sweep_step   <= dslst_pkg::RST_STEP;
         cfg_ff.confirm      <= dslst_pkg::RST_CONFIRM;
         cfg_ff.floor_mdeg   <= dslst_pkg::RST_FLOOR;
         cfg_ff.limit_mdeg   <= dslst_pkg::RST_LIMIT;
         cfg_ff.restart_mdeg <= dslst_pkg::RST_RESTART;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            dslst_pkg::REG_DEADBAND: cfg_ff.deadband     <= csr_bus.data[8:0];
            dslst_pkg::REG_GAIN:     cfg_ff.gain         <= csr_bus.data[7:0];
            dslst_pkg::REG_CENTER:   cfg_ff.center       <= csr_bus.data[9:0];
            dslst_pkg::REG_STEP:     cfg_ff.sweep_step   <= csr_bus.data[13:0];
            dslst_pkg::REG_CONFIRM:  cfg_ff.confirm      <= csr_bus.data[4:0];
            dslst_pkg::REG_FLOOR:    cfg_ff.floor_mdeg   <= csr_bus.data;
            dslst_pkg::REG_LIMIT:    cfg_ff.limit_mdeg   <= csr_bus.data;
            dslst_pkg::REG_RESTART:  cfg_ff.restart_mdeg <= csr_bus.data;
            default: ;
         endcase
      end
   end

   dslst_step u_step (
      .cfg  (cfg_ff),
      .cur  (state_ff),
      .item (a_item_ff),
      .nxt  (state_in),
      .ev   (step_ev)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff           <= 1'b0;
         b_valid_ff           <= 1'b0;
         rsp_valid_ff         <= 1'b0;
         state_ff.left_angle  <= dslst_pkg::CENTER_ANGLE;
         state_ff.right_angle <= dslst_pkg::CENTER_ANGLE;
         state_ff.mode        <= dslst_pkg::MODE_IDLE;
         state_ff.counter     <= '0;
      end else begin
         if (a_free) a_valid_ff <= req_bus.valid;
         if (b_free) b_valid_ff <= a_valid_ff;
         if (out_free) rsp_valid_ff <= b_valid_ff;
         if (a_move) state_ff <= state_in;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (req_take) begin
         a_item_ff.kind    <= req_bus.kind;
         a_item_ff.command <= req_bus.command;
         a_item_ff.left_x  <= req_bus.left_x;
         a_item_ff.right_x <= req_bus.right_x;
      end
      if (a_move) begin
         b_state_ff <= state_in;
         b_ev_ff    <= step_ev;
      end
      if (b_move) begin
         rsp_left_ff  <= dslst_pkg::mdeg_to_deg(b_state_ff.left_angle);
         rsp_right_ff <= dslst_pkg::mdeg_to_deg(b_state_ff.right_angle);
         rsp_mode_ff  <= b_state_ff.mode;
         rsp_ev_ff    <= b_ev_ff;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.left_servo_deg  = rsp_left_ff;
   assign rsp_bus.right_servo_deg = rsp_right_ff;
   assign rsp_bus.active_mode     = rsp_mode_ff;
   assign rsp_bus.event_res       = rsp_ev_ff;

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.left_angle <= dslst_pkg::ANGLE_MAX && state_ff.right_angle <= dslst_pkg::ANGLE_MAX)
      else $error("track angle above ceiling");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !a_move |=> $stable(state_ff))
      else $error("track state changed without a transfer");

   a_b_stall: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && !out_free |=> b_valid_ff && $stable(b_state_ff) && $stable(b_ev_ff))
      else $error("middle stage lost its item under stall");

   a_event_mode: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && (b_ev_ff == dslst_pkg::EV_FOUND) |-> b_state_ff.mode == dslst_pkg::MODE_FOLLOW)
      else $error("found event without follow mode");

   a_idle_events: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && (b_ev_ff == dslst_pkg::EV_NOT_FOUND || b_ev_ff == dslst_pkg::EV_EXTINGUISH)
      |-> b_state_ff.mode == dslst_pkg::MODE_IDLE)
      else $error("give-up or extinguish event without idle mode");

endmodule

// ===== hw/rtl/dslst_step.sv =====
module dslst_step (
   input  dslst_pkg::cfg_type         cfg,
   input  dslst_pkg::track_state_type cur,
   input  dslst_pkg::item_type        item,
   output dslst_pkg::track_state_type nxt,
   output dslst_pkg::event_type       ev
);

   logic                          run;
   logic                          left_hit;
   logic                          right_hit;
   logic [dslst_pkg::ANGLE_W-1:0] la;
   logic [dslst_pkg::ANGLE_W-1:0] ra;
   logic [dslst_pkg::ANGLE_W-1:0] thr;
   logic [dslst_pkg::ANGLE_W-1:0] restart_sat;
   logic [4:0]                    cnt;

   function automatic logic [dslst_pkg::ANGLE_W-1:0] sat_add(
      logic [dslst_pkg::ANGLE_W-1:0] a, logic [13:0] s);
      logic [dslst_pkg::ANGLE_W:0] sum;
      sum = {1'b0, a} + 19'(s);
      return (sum > {1'b0, dslst_pkg::ANGLE_MAX}) ? dslst_pkg::ANGLE_MAX
                                                  : sum[dslst_pkg::ANGLE_W-1:0];
   endfunction

   function automatic logic [dslst_pkg::ANGLE_W-1:0] follow_side(
      logic [dslst_pkg::ANGLE_W-1:0] angle, logic [9:0] x, dslst_pkg::cfg_type c);
      logic signed [11:0] err;
      logic signed [11:0] marg;
      logic signed [20:0] prod;
      logic signed [20:0] v;
      logic signed [20:0] fl;
      err  = $signed({2'b00, x}) - $signed({2'b00, c.center});
      marg = $signed({3'b000, c.deadband});
      prod = $signed({13'd0, c.gain}) * 21'(err);
      v    = prod + $signed({3'b000, angle});
      fl   = $signed({3'b000, c.floor_mdeg});
      if (x == dslst_pkg::NO_BLOB || (err >= -marg && err <= marg)) begin
         return angle;
      end
      if (v < fl) begin
         v = fl;
      end
      if (v > $signed({3'b000, dslst_pkg::ANGLE_MAX})) begin
         return dslst_pkg::ANGLE_MAX;
      end
      return v[dslst_pkg::ANGLE_W-1:0];
   endfunction

   assign thr = (cfg.limit_mdeg >= dslst_pkg::RESTART_MARGIN)
              ? cfg.limit_mdeg - dslst_pkg::RESTART_MARGIN : '0;
   assign restart_sat = (cfg.restart_mdeg > dslst_pkg::ANGLE_MAX)
                      ? dslst_pkg::ANGLE_MAX : cfg.restart_mdeg;

   always_comb begin
      nxt       = cur;
      ev        = dslst_pkg::EV_NONE;
      run       = 1'b1;
      left_hit  = 1'b0;
      right_hit = 1'b0;
      la        = '0;
      ra        = '0;
      cnt       = cur.counter;

      // mode command goes first; extinguish, report and center skip the sample
      if (item.kind) begin
         case (item.command) inside
            dslst_pkg::CMD_SEARCH: nxt.mode = dslst_pkg::MODE_SEARCH;
            dslst_pkg::CMD_FOLLOW: nxt.mode = dslst_pkg::MODE_FOLLOW;
            dslst_pkg::CMD_EXTINGUISH: begin
               nxt.mode = dslst_pkg::MODE_IDLE;
               ev       = dslst_pkg::EV_EXTINGUISH;
               run      = 1'b0;
            end
            dslst_pkg::CMD_REPORT: begin
               ev  = dslst_pkg::EV_REPORT;
               run = 1'b0;
            end
            dslst_pkg::CMD_CENTER: begin
               nxt.left_angle  = dslst_pkg::CENTER_ANGLE;
               nxt.right_angle = dslst_pkg::CENTER_ANGLE;
               run             = 1'b0;
            end
            dslst_pkg::CMD_IDLE,
            [dslst_pkg::CMD_IDLE_ALT_LO:dslst_pkg::CMD_IDLE_ALT_HI]:
               nxt.mode = dslst_pkg::MODE_IDLE;
            default: ;
         endcase
      end

      if (run) begin
         case (nxt.mode)
            dslst_pkg::MODE_SEARCH: begin
               la = nxt.left_angle;
               ra = nxt.right_angle;
               if (la < cfg.limit_mdeg) begin
                  if (item.left_x == dslst_pkg::NO_BLOB) la = sat_add(la, cfg.sweep_step);
                  else left_hit = 1'b1;
               end
               if (ra < cfg.limit_mdeg) begin
                  if (item.right_x == dslst_pkg::NO_BLOB) ra = sat_add(ra, cfg.sweep_step);
                  else right_hit = 1'b1;
               end
               if (left_hit && right_hit) begin
                  if (cnt < dslst_pkg::CNT_MAX) cnt = cnt + 5'd1;
                  if (cnt > cfg.confirm) begin
                     nxt.mode = dslst_pkg::MODE_FOLLOW;
                     cnt      = '0;
                     ev       = dslst_pkg::EV_FOUND;
                  end
               end else if (ra >= thr || la >= thr) begin
                  // sweep ran out: give up only when both sides went far
                  if (ra >= dslst_pkg::GIVE_UP_ANGLE && la >= dslst_pkg::GIVE_UP_ANGLE) begin
                     nxt.mode = dslst_pkg::MODE_IDLE;
                     ev       = dslst_pkg::EV_NOT_FOUND;
                  end
                  la = restart_sat;
                  ra = restart_sat;
               end
               nxt.left_angle  = la;
               nxt.right_angle = ra;
               nxt.counter     = cnt;
            end
            dslst_pkg::MODE_FOLLOW: begin
               nxt.left_angle  = follow_side(nxt.left_angle, item.left_x, cfg);
               nxt.right_angle = follow_side(nxt.right_angle, item.right_x, cfg);
            end
            default: ;
         endcase
      end
   end

endmodule
